// ===== rtl/lru_pkg.sv =====
// shared widths, limits and reset values for the lru page replacement block
`default_nettype none

package lru_pkg;

    localparam int PAGE_W         = 8;
    localparam int SLOT_W         = 3;
    localparam int CNT_W          = 16;
    localparam int CFG_W          = 4;
    localparam int MAX_FRAMES_DEF = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/lru_if.sv =====
// valid/ready channel interfaces for page references and replacement results
`default_nettype none

interface lru_in_if;
    logic                      valid;
    logic                      ready;
    logic [lru_pkg::PAGE_W-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lru_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [lru_pkg::SLOT_W-1:0] frame_slot;
    logic                       evicted_valid;
    logic [lru_pkg::PAGE_W-1:0] evicted_page;
    logic [lru_pkg::CNT_W-1:0]  hit_total;
    logic [lru_pkg::CNT_W-1:0]  fault_total;

    modport source (output valid, output hit, output frame_slot, output evicted_valid,
                    output evicted_page, output hit_total, output fault_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                    input evicted_page, input hit_total, input fault_total,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_cell.sv =====
// one frame cell: holds page, valid and recency rank, passes the lookup record on
`default_nettype none

module lru_cell #(
    parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
    parameter int INDEX      = 0
) (
    i_clk,
    i_rst_n,
    i_active,
    i_rec,
    o_rec,
    i_upd
);
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

    typedef struct packed {
        logic                       valid;
        logic [lru_pkg::PAGE_W-1:0] page;
        logic                       found;
        logic [IDX_W-1:0]           f_slot;
        logic [IDX_W-1:0]           f_rank;
        logic                       empty;
        logic [IDX_W-1:0]           e_slot;
        logic [IDX_W-1:0]           e_rank;
        logic                       best_any;
        logic [IDX_W-1:0]           b_slot;
        logic [IDX_W-1:0]           b_rank;
        logic [lru_pkg::PAGE_W-1:0] b_page;
    } t_rec;

    typedef struct packed {
        logic                       en;
        logic [IDX_W-1:0]           slot;
        logic [IDX_W-1:0]           rank;
        logic                       fill;
        logic [lru_pkg::PAGE_W-1:0] page;
    } t_upd;

    input  wire logic i_clk;
    input  wire logic i_rst_n;
    input  wire logic i_active;
    input  wire t_rec i_rec;
    output t_rec      o_rec;
    input  wire t_upd i_upd;

    logic [lru_pkg::PAGE_W-1:0] r_page;
    logic                       r_valid;
    logic [IDX_W-1:0]           r_rank;
    logic                       r_rec_vld;
    t_rec                       r_rec;
    t_rec                       n_rec;
    logic                       w_match;

    always_comb begin
        n_rec   = i_rec;
        w_match = i_active && r_valid && (r_page == i_rec.page);
        if (!i_rec.found && w_match) begin
            n_rec.found  = 1'b1;
            n_rec.f_slot = IDX;
            n_rec.f_rank = r_rank;
        end
        if (!i_rec.empty && i_active && !r_valid) begin
            n_rec.empty  = 1'b1;
            n_rec.e_slot = IDX;
            n_rec.e_rank = r_rank;
        end
        if (i_active && (!i_rec.best_any || (r_rank > i_rec.b_rank))) begin
            n_rec.best_any = 1'b1;
            n_rec.b_slot   = IDX;
            n_rec.b_rank   = r_rank;
            n_rec.b_page   = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_vld <= 1'b0;
        end else begin
            r_rec_vld <= i_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_comb begin
        o_rec       = r_rec;
        o_rec.valid = r_rec_vld;
    end

    // frame state and recency update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page  <= '0;
            r_valid <= 1'b0;
            r_rank  <= IDX;
        end else if (i_upd.en) begin
            if (i_upd.slot == IDX) begin
                r_rank <= '0;
                if (i_upd.fill) begin
                    r_page  <= i_upd.page;
                    r_valid <= 1'b1;
                end
            end else if (r_rank < i_upd.rank) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement_core.sv =====
// top level of the lru page replacement block: frame cell chain, sequencer, totals
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  i_in     | in  | valid/ready          | page
//  o_out    | out | valid/ready          | hit, frame_slot, evicted_valid,
//           |     |                      | evicted_page, hit_total, fault_total
//  cfg      | in  | i_cfg_we             | i_cfg_data (frames_in_use)
//
//  each beat enters while idle, its lookup record is registered by each frame cell in
//  turn, the decision is registered, then the commit updates cells and loads the result.
//  the next beat is taken as soon as the commit is done, even if the result waits.
//  a commit stalls while the previous result has not been taken.
//  reset is synchronous, active low; frames come up empty with rank equal to index.
`default_nettype none

module lru_page_replacement_core #(
    parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [lru_pkg::CFG_W-1:0] i_cfg_data,
    lru_in_if.sink                         i_in,
    lru_out_if.source                      o_out
);
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic [lru_pkg::PAGE_W-1:0] page;
        logic                       found;
        logic [IDX_W-1:0]           f_slot;
        logic [IDX_W-1:0]           f_rank;
        logic                       empty;
        logic [IDX_W-1:0]           e_slot;
        logic [IDX_W-1:0]           e_rank;
        logic                       best_any;
        logic [IDX_W-1:0]           b_slot;
        logic [IDX_W-1:0]           b_rank;
        logic [lru_pkg::PAGE_W-1:0] b_page;
    } t_rec;

    typedef struct packed {
        logic                       en;
        logic [IDX_W-1:0]           slot;
        logic [IDX_W-1:0]           rank;
        logic                       fill;
        logic [lru_pkg::PAGE_W-1:0] page;
    } t_upd;

    logic [1:0]                 r_state;
    logic [lru_pkg::CFG_W-1:0]  r_cfg;
    logic [MAX_FRAMES-1:0]      w_active;
    t_rec                       w_rec [MAX_FRAMES+1];
    t_rec                       w_tail;
    t_upd                       w_upd;
    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_commit;

    logic                       r_dec_hit;
    logic [IDX_W-1:0]           r_dec_slot;
    logic [IDX_W-1:0]           r_dec_rank;
    logic                       r_dec_ev;
    logic [lru_pkg::PAGE_W-1:0] r_dec_evpage;
    logic [lru_pkg::PAGE_W-1:0] r_dec_page;
    logic [IDX_W-1:0]           n_dec_slot;
    logic [IDX_W-1:0]           n_dec_rank;

    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [lru_pkg::SLOT_W-1:0] r_out_slot;
    logic                       r_out_ev;
    logic [lru_pkg::PAGE_W-1:0] r_out_evpage;
    logic [lru_pkg::CNT_W-1:0]  r_hit_cnt;
    logic [lru_pkg::CNT_W-1:0]  r_fault_cnt;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = (r_state == S_DONE) && w_out_free;
    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lru_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // a zero count still keeps frame 0 active; large counts clamp at the chain length
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_active[i] = (i == 0) || (int'(r_cfg) > i);
        end
    end

    always_comb begin
        w_rec[0]       = '0;
        w_rec[0].valid = w_in_acc;
        w_rec[0].page  = i_in.page;
    end

    assign w_tail = w_rec[MAX_FRAMES];

    assign w_upd.en   = w_commit;
    assign w_upd.slot = r_dec_slot;
    assign w_upd.rank = r_dec_rank;
    assign w_upd.fill = !r_dec_hit;
    assign w_upd.page = r_dec_page;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lru_cell #(
            .MAX_FRAMES (MAX_FRAMES),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (w_active[g]),
            .i_rec    (w_rec[g]),
            .o_rec    (w_rec[g+1]),
            .i_upd    (w_upd)
        );
    end

    always_comb begin
        if (w_tail.found) begin
            n_dec_slot = w_tail.f_slot;
            n_dec_rank = w_tail.f_rank;
        end else if (w_tail.empty) begin
            n_dec_slot = w_tail.e_slot;
            n_dec_rank = w_tail.e_rank;
        end else begin
            n_dec_slot = w_tail.b_slot;
            n_dec_rank = w_tail.b_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_tail.valid) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WALK) && w_tail.valid) begin
            r_dec_hit    <= w_tail.found;
            r_dec_slot   <= n_dec_slot;
            r_dec_rank   <= n_dec_rank;
            r_dec_ev     <= !w_tail.found && !w_tail.empty;
            r_dec_evpage <= (!w_tail.found && !w_tail.empty) ? w_tail.b_page : '0;
            r_dec_page   <= w_tail.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if (r_dec_hit) begin
                    if (r_hit_cnt != lru_pkg::CNT_MAX) r_hit_cnt <= r_hit_cnt + 1'b1;
                end else begin
                    if (r_fault_cnt != lru_pkg::CNT_MAX) r_fault_cnt <= r_fault_cnt + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_hit    <= r_dec_hit;
            r_out_slot   <= lru_pkg::SLOT_W'(r_dec_slot);
            r_out_ev     <= r_dec_ev;
            r_out_evpage <= r_dec_evpage;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.frame_slot    = r_out_slot;
    assign o_out.evicted_valid = r_out_ev;
    assign o_out.evicted_page  = r_out_evpage;
    assign o_out.hit_total     = r_hit_cnt;
    assign o_out.fault_total   = r_fault_cnt;

endmodule

`default_nettype wire

// ===== rtl/lru_checker.sv =====
// port-level checker for the lru page replacement core, bound to the top level
`default_nettype none

module lru_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic                       i_hit,
    input wire logic                       i_ev_valid,
    input wire logic [lru_pkg::PAGE_W-1:0] i_ev_page,
    input wire logic [lru_pkg::CNT_W-1:0]  i_hit_total,
    input wire logic [lru_pkg::CNT_W-1:0]  i_fault_total
);

    // result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    // one reference at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("reference taken while previous one still in flight");

    // a hit never evicts, a miss without eviction reports page zero
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_hit && !i_ev_valid && (i_ev_page == '0)) ||
                         (!i_hit && (i_ev_valid || (i_ev_page == '0)))))
        else $error("eviction fields inconsistent with hit flag");

    // totals step by one on a fresh result, or hold once saturated
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(i_out_valid) && $past(i_rst_n)) |->
        (i_hit ?
            (((i_hit_total == $past(i_hit_total) + 16'd1) ||
              ((i_hit_total == lru_pkg::CNT_MAX) && ($past(i_hit_total) == lru_pkg::CNT_MAX)))
             && (i_fault_total == $past(i_fault_total))) :
            (((i_fault_total == $past(i_fault_total) + 16'd1) ||
              ((i_fault_total == lru_pkg::CNT_MAX) &&
               ($past(i_fault_total) == lru_pkg::CNT_MAX)))
             && (i_hit_total == $past(i_hit_total)))))
        else $error("running totals did not follow the result");

endmodule

bind lru_page_replacement_core lru_checker u_lru_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_hit         (o_out.hit),
    .i_ev_valid    (o_out.evicted_valid),
    .i_ev_page     (o_out.evicted_page),
    .i_hit_total   (o_out.hit_total),
    .i_fault_total (o_out.fault_total)
);

`default_nettype wire
